/* src/bree_pkg.sv */
`default_nettype none

package bree_pkg;

  localparam int MaxBits   = 65536;
  localparam int WordBits  = 64;
  localparam int NumWords  = (MaxBits + WordBits - 1) / WordBits;
  localparam int AddrW     = $clog2(NumWords);
  localparam int IdxW      = $clog2(WordBits);
  localparam int SizeW     = 17;
  localparam int PosW      = 16;
  localparam int InTdataW  = 40;
  localparam int OutTdataW = 40;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 32;

  localparam logic [SizeW-1:0] SizeMax   = SizeW'(MaxBits);
  localparam logic [SizeW-1:0] SizeReset = SizeW'(MaxBits);

  localparam logic [0:0] REG_BITMAP_SIZE = 1'b0;

  typedef enum logic [1:0] {
    ACT_SET        = 2'd0,
    ACT_CLEAR      = 2'd1,
    ACT_FIND_SET   = 2'd2,
    ACT_FIND_CLEAR = 2'd3
  } action_e;

  typedef struct packed {
    logic            lo_en;
    logic [IdxW-1:0] lo;
    logic            hi_en;
    logic [IdxW-1:0] hi;
    logic            val;
    logic            inv;
  } wu_ctl_t;

  typedef struct packed {
    logic [WordBits-1:0] wdata;
    logic                hit;
    logic [IdxW-1:0]     pos;
  } wu_res_t;

endpackage

`default_nettype wire

/* src/bree_ram.sv */
`default_nettype none

module bree_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024,
  localparam int AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/bree_word_unit.sv */
`default_nettype none

module bree_word_unit (
  input  logic [bree_pkg::WordBits-1:0] word_i,
  input  bree_pkg::wu_ctl_t             ctl_i,
  output bree_pkg::wu_res_t             res_o
);

  import bree_pkg::*;

  logic [WordBits-1:0] mask;
  logic [WordBits-1:0] look;
  logic                look_val;

  always_comb begin
    look_val = ctl_i.val ^ ctl_i.inv;
    for (int i = 0; i < WordBits; i++) begin
      mask[i] = (!ctl_i.lo_en || (IdxW'(i) >= ctl_i.lo)) &&
                (!ctl_i.hi_en || (IdxW'(i) <= ctl_i.hi));
    end
    look        = (look_val ? word_i : ~word_i) & mask;
    res_o.wdata = ctl_i.val ? (word_i | mask) : (word_i & ~mask);
    res_o.hit   = |look;
    res_o.pos   = '0;
    // lowest matching bit wins
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (look[i]) begin
        res_o.pos = IdxW'(i);
      end
    end
  end

endmodule

`default_nettype wire

/* src/bitmap_range_extent_engine_top.sv */
// Bitmap range and extent engine: a 65536-bit bitmap held as 1024 words of 64 bits.
// Commands arrive as beats on the s_axis channel (tuser = action, tdata = start
// and length); each command yields exactly one result beat on m_axis (tuser = ok,
// tdata = extent start and length). Set/clear a range, or find the next run of
// set or clear bits at or after an offset, bounded by the bitmap_size register
// written over the APB port (address 0, read back on prdata).
// The block works on one command at a time; s_axis_tready is high only when idle.
// Each command visits one bitmap word per cycle through the RAM's single read
// port and one shared mask/priority word unit. A search rescans the word where
// the run start is found to look for the run end. Rejected ranges and searches
// from at or beyond the size go straight from the prepare state to the output.
// After reset a clearing pass writes zero to every word, during which no
// command is taken; register writes are taken at any time.
// The result sits in an output register: the next command is accepted while
// it waits, and a finished result waits (holding the engine) until m_axis_tready.

`default_nettype none

module bitmap_range_extent_engine_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [16:0] start_bit, [33:17] run_length, rest zero
  input  logic [bree_pkg::InTdataW-1:0]      s_axis_tdata,
  // [1:0] action
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [15:0] extent_start, [32:16] extent_bits, rest zero
  output logic [bree_pkg::OutTdataW-1:0]     m_axis_tdata,
  // [0] ok
  output logic [0:0]                         m_axis_tuser,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bree_pkg::CfgAddrW-1:0]      paddr,
  input  logic [bree_pkg::CfgDataW-1:0]      pwdata,
  output logic [bree_pkg::CfgDataW-1:0]      prdata,
  output logic                               pready
);

  import bree_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_FIND  = 3'd4;
  localparam logic [2:0] ST_RUN   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [SizeW-1:0] size_q;
  action_e          act_q;
  logic [SizeW-1:0] sb_q, rl_q;
  logic [AddrW-1:0] wfirst_q, wfirst_d, wlast_q, wlast_d;
  logic [AddrW-1:0] wcur_q, wcur_d, ra_q, ra_d;
  logic [IdxW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic             iss_q, iss_d, dval_q, dval_d, lofirst_q, lofirst_d;
  logic [PosW-1:0]  ps_q, ps_d, rs_q, rs_d;
  logic             rok_q, rok_d;
  logic [SizeW-1:0] rlen_q, rlen_d;
  logic             mval_q, mval_d, mok_q;
  logic [PosW-1:0]  mstart_q;
  logic [SizeW-1:0] mbits_q;

  logic             in_acc, cfg_we, out_load;
  logic [SizeW-1:0] size_use, lastb, sm1;
  logic [SizeW:0]   endp;

  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  logic [WordBits-1:0] ram_wdata, ram_rdata;
  wu_ctl_t             wu_ctl;
  wu_res_t             wu_res;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign pready        = 1'b1;
  assign cfg_we        = psel & penable & pwrite &
                         (paddr[CfgAddrW-1:CfgAddrW-1] == REG_BITMAP_SIZE);
  assign prdata        = (paddr[CfgAddrW-1:CfgAddrW-1] == REG_BITMAP_SIZE) ?
                         CfgDataW'(size_q) : '0;

  assign size_use = (size_q > SizeMax) ? SizeMax : size_q;
  assign endp     = {1'b0, sb_q} + {1'b0, rl_q};
  assign lastb    = endp[SizeW-1:0] - SizeW'(1);
  assign sm1      = size_use - SizeW'(1);
  assign out_load = (state_q == ST_OUT) && (!mval_q || m_axis_tready);

  always_comb begin
    wu_ctl.lo    = lo_q;
    wu_ctl.hi    = hi_q;
    wu_ctl.hi_en = (wcur_q == wlast_q);
    if (state_q == ST_WRITE) begin
      wu_ctl.lo_en = (wcur_q == wfirst_q);
      wu_ctl.val   = (act_q == ACT_SET);
      wu_ctl.inv   = 1'b0;
    end else begin
      wu_ctl.lo_en = lofirst_q;
      wu_ctl.val   = (act_q == ACT_FIND_SET);
      wu_ctl.inv   = (state_q == ST_RUN);
    end
  end

  assign ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_WRITE) && dval_q);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : wcur_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : wu_res.wdata;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    wfirst_d  = wfirst_q;
    wlast_d   = wlast_q;
    wcur_d    = wcur_q;
    ra_d      = ra_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    iss_d     = iss_q;
    dval_d    = dval_q;
    lofirst_d = lofirst_q;
    ps_d      = ps_q;
    rs_d      = rs_q;
    rok_d     = rok_q;
    rlen_d    = rlen_q;
    ram_re    = 1'b0;
    ram_raddr = wcur_q + AddrW'(1);
    mval_d    = mval_q & ~m_axis_tready;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AddrW'(1);
        if (clr_q == AddrW'(NumWords - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        rok_d  = 1'b0;
        rs_d   = '0;
        rlen_d = '0;
        dval_d = 1'b0;
        if (act_q inside {ACT_SET, ACT_CLEAR}) begin
          if (endp > {1'b0, size_use}) begin
            state_d = ST_OUT;
          end else if (rl_q == '0) begin
            rok_d   = 1'b1;
            state_d = ST_OUT;
          end else begin
            wfirst_d = sb_q[PosW-1:IdxW];
            wlast_d  = lastb[PosW-1:IdxW];
            lo_d     = sb_q[IdxW-1:0];
            hi_d     = lastb[IdxW-1:0];
            ra_d     = sb_q[PosW-1:IdxW];
            iss_d    = 1'b1;
            state_d  = ST_WRITE;
          end
        end else begin
          if (sb_q >= size_use) begin
            state_d = ST_OUT;
          end else begin
            wlast_d   = sm1[PosW-1:IdxW];
            hi_d      = sm1[IdxW-1:0];
            lo_d      = sb_q[IdxW-1:0];
            lofirst_d = 1'b1;
            wcur_d    = sb_q[PosW-1:IdxW];
            ram_re    = 1'b1;
            ram_raddr = sb_q[PosW-1:IdxW];
            state_d   = ST_FIND;
          end
        end
      end
      ST_WRITE: begin
        // read one word ahead, modify and write back the word in hand
        if (iss_q) begin
          ram_re    = 1'b1;
          ram_raddr = ra_q;
          ra_d      = ra_q + AddrW'(1);
          wcur_d    = ra_q;
          if (ra_q == wlast_q) begin
            iss_d = 1'b0;
          end
        end
        dval_d = iss_q;
        if (dval_q && (wcur_q == wlast_q)) begin
          rok_d   = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_FIND: begin
        if (wu_res.hit) begin
          // rescan the same word for the run end; read data holds
          ps_d      = {wcur_q, wu_res.pos};
          lo_d      = wu_res.pos;
          lofirst_d = 1'b1;
          state_d   = ST_RUN;
        end else if (wcur_q == wlast_q) begin
          state_d = ST_OUT;
        end else begin
          ram_re    = 1'b1;
          wcur_d    = wcur_q + AddrW'(1);
          lofirst_d = 1'b0;
        end
      end
      ST_RUN: begin
        if (wu_res.hit) begin
          rok_d   = 1'b1;
          rs_d    = ps_q;
          rlen_d  = {1'b0, wcur_q, wu_res.pos} - {1'b0, ps_q};
          state_d = ST_OUT;
        end else if (wcur_q == wlast_q) begin
          rok_d   = 1'b1;
          rs_d    = ps_q;
          rlen_d  = size_use - {1'b0, ps_q};
          state_d = ST_OUT;
        end else begin
          ram_re    = 1'b1;
          wcur_d    = wcur_q + AddrW'(1);
          lofirst_d = 1'b0;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          mval_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      size_q  <= SizeReset;
      iss_q   <= 1'b0;
      dval_q  <= 1'b0;
      mval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      iss_q   <= iss_d;
      dval_q  <= dval_d;
      mval_q  <= mval_d;
      if (cfg_we) begin
        size_q <= pwdata[SizeW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= action_e'(s_axis_tuser);
      sb_q  <= s_axis_tdata[SizeW-1:0];
      rl_q  <= s_axis_tdata[2*SizeW-1:SizeW];
    end
    wfirst_q  <= wfirst_d;
    wlast_q   <= wlast_d;
    wcur_q    <= wcur_d;
    ra_q      <= ra_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    lofirst_q <= lofirst_d;
    ps_q      <= ps_d;
    rs_q      <= rs_d;
    rok_q     <= rok_d;
    rlen_q    <= rlen_d;
    if (out_load) begin
      mok_q    <= rok_q;
      mstart_q <= rs_q;
      mbits_q  <= rlen_q;
    end
  end

  assign m_axis_tvalid = mval_q;
  assign m_axis_tuser  = mok_q;
  assign m_axis_tdata  = {(OutTdataW - PosW - SizeW)'(0), mbits_q, mstart_q};

  bree_ram #(
    .Width (WordBits),
    .Depth (NumWords)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bree_word_unit u_word_unit (
    .word_i (ram_rdata),
    .ctl_i  (wu_ctl),
    .res_o  (wu_res)
  );

`ifndef ASSERT_OFF
  a_search_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIND || state_q == ST_RUN) |-> !ram_we)
    else $error("bitmap written during a search");

  a_null_extent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mval_q && !mok_q) |-> (mstart_q == '0 && mbits_q == '0))
    else $error("failed result carries a non-null extent");

  a_write_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE && dval_q) |-> (wcur_q >= wfirst_q && wcur_q <= wlast_q))
    else $error("range write outside its word span");

  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (wcur_q >= ps_q[PosW-1:IdxW]))
    else $error("run scan behind run start");
`endif

endmodule

`default_nettype wire
